### hdl/cln_pkg.sv
// Shared types and constants of the column L2-norm normalizer.
package cln_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int NCOL_W      = COL_W + 1;
   localparam int VAL_W       = 32;
   localparam int RES_W       = 33;
   localparam int SUM_W       = 64;
   localparam int STEPS       = 32;
   localparam int STEP_W      = $clog2(STEPS);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

   localparam logic [NCOL_W-1:0] NCOL_RESET = NCOL_W'(16);

   // input action codes
   localparam logic [1:0] ACT_ACC = 2'd0;
   localparam logic [1:0] ACT_FIN = 2'd1;
   localparam logic [1:0] ACT_NRM = 2'd2;

   // result kinds
   localparam logic KIND_ELEM = 1'b0;
   localparam logic KIND_NORM = 1'b1;

   typedef enum logic [1:0] {
      OP_ACC,
      OP_FIN,
      OP_NRM
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [COL_W-1:0]    col;
      logic                neg;
      logic [VAL_W-1:0]    mag;
   } cmd_type;

endpackage

### hdl/column_two_norm_normalizer_top.sv
// Top level of the column L2-norm normalizer.
// Back end: accumulate, normalize (32-step restoring divide) and finalize (32-step
//   square root per column, one norm beat each).
// The back end takes one command at a time; a 4-entry queue takes beats meanwhile.
// Reset (synchronous, high) clears queue, state, result register and the valid
//   bits of both stores; sums and norms then read as zero.
module column_two_norm_normalizer_top
   import cln_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [NCOL_W-1:0]        csr_wr_data,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [1:0]               req_action,
   input  logic [COL_W-1:0]         req_column,
   input  logic signed [VAL_W-1:0]  req_elem_value,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic                     rsp_result_kind,
   output logic [COL_W-1:0]         rsp_result_column,
   output logic signed [RES_W-1:0]  rsp_result_value,
   output logic                     rsp_zero_norm,
   output logic                     rsp_last_result
);

   cmd_type           push_cmd;
   cmd_type           head;
   logic              fifo_push, fifo_full, fifo_pop, fifo_empty;
   logic [NCOL_W-1:0] ncols;

   assign req_full = fifo_full;

   // front: register, filter of columns out of range and unused codes
   cln_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_push       (req_push),
      .req_action     (req_action),
      .req_column     (req_column),
      .req_elem_value (req_elem_value),
      .fifo_full      (fifo_full),
      .fifo_push      (fifo_push),
      .fifo_cmd       (push_cmd),
      .ncols          (ncols)
   );

   cln_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (fifo_pop),
      .head     (head),
      .empty    (fifo_empty)
   );

   // back: one command at a time, results through a one-beat register
   cln_back u_back (
      .clock             (clock),
      .reset             (reset),
      .ncols             (ncols),
      .head              (head),
      .fifo_empty        (fifo_empty),
      .fifo_pop          (fifo_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_result_column (rsp_result_column),
      .rsp_result_value  (rsp_result_value),
      .rsp_zero_norm     (rsp_zero_norm),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

### hdl/cln_front.sv
// Front end: column-count register, item filtering and magnitude split.
module cln_front
   import cln_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [NCOL_W-1:0]        csr_wr_data,
   input  logic                     req_push,
   input  logic [1:0]               req_action,
   input  logic [COL_W-1:0]         req_column,
   input  logic signed [VAL_W-1:0]  req_elem_value,
   input  logic                     fifo_full,
   output logic                     fifo_push,
   output cmd_type                  fifo_cmd,
   output logic [NCOL_W-1:0]        ncols
);

   logic [NCOL_W-1:0] ncol_ff;
   logic [NCOL_W-1:0] ncol_in;
   logic              keep;

   always_comb begin
      ncol_in = csr_wr_en ? csr_wr_data : ncol_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ncol_ff <= NCOL_RESET;
      end else begin
         ncol_ff <= ncol_in;
      end
   end

   // clamp to 1..MAX_COLUMNS
   always_comb begin
      if (ncol_ff == '0) begin
         ncols = NCOL_W'(1);
      end else if (ncol_ff > NCOL_W'(MAX_COLUMNS)) begin
         ncols = NCOL_W'(MAX_COLUMNS);
      end else begin
         ncols = ncol_ff;
      end
   end

   always_comb begin
      fifo_cmd.col = req_column;
      fifo_cmd.neg = req_elem_value[VAL_W-1];
      fifo_cmd.mag = req_elem_value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(req_elem_value))
                                             : VAL_W'(req_elem_value);
      fifo_cmd.op  = OP_ACC;
      keep         = 1'b0;
      case (req_action)
         ACT_ACC: begin
            fifo_cmd.op = OP_ACC;
            keep        = {1'b0, req_column} < ncols;
         end
         ACT_FIN: begin
            fifo_cmd.op = OP_FIN;
            keep        = 1'b1;
         end
         ACT_NRM: begin
            fifo_cmd.op = OP_NRM;
            keep        = {1'b0, req_column} < ncols;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      fifo_push = req_push & ~fifo_full & keep;
   end

endmodule

### hdl/cln_fifo.sv
// Short command queue between front and back end.
module cln_fifo
   import cln_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type               slot_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]    wptr_ff, wptr_in;
   logic [FIFO_AW-1:0]    rptr_ff, rptr_in;
   logic [FIFO_AW:0]      cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   always_comb begin
      full    = cnt_ff == (FIFO_AW+1)'(FIFO_DEPTH);
      empty   = cnt_ff == '0;
      do_push = push & ~full;
      do_pop  = pop & ~empty;
      head    = slot_ff[rptr_ff];
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/cln_back.sv
// Back end: sum and norm stores, iterative square root and divider, result register.
module cln_back
   import cln_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [NCOL_W-1:0]        ncols,
   input  cmd_type                  head,
   input  logic                     fifo_empty,
   output logic                     fifo_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output logic                     rsp_result_kind,
   output logic [COL_W-1:0]         rsp_result_column,
   output logic signed [RES_W-1:0]  rsp_result_value,
   output logic                     rsp_zero_norm,
   output logic                     rsp_last_result
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_ADD,
      ST_F_RD,
      ST_F_INIT,
      ST_F_SQ,
      ST_F_OUT,
      ST_N_CHK,
      ST_N_DIV,
      ST_N_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 neg_ff, neg_in;
   logic [VAL_W-1:0]     mag_ff, mag_in;
   logic [SUM_W-1:0]     prod_ff, prod_in;
   logic [SUM_W-1:0]     x_ff, x_in;
   logic [SUM_W-1:0]     res_ff, res_in;
   logic [SUM_W-1:0]     bit_ff, bit_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [VAL_W-1:0]     rem_ff, rem_in;
   logic [VAL_W-1:0]     q_ff, q_in;
   logic [VAL_W-1:0]     dl_ff, dl_in;
   logic [VAL_W-1:0]     nv_ff, nv_in;
   logic                 ovf_ff, ovf_in;

   logic                 out_vld_ff, out_vld_in;
   logic                 out_kind_ff, out_kind_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [RES_W-1:0]     out_val_ff, out_val_in;
   logic                 out_zero_ff, out_zero_in;
   logic                 out_last_ff, out_last_in;

   // stores
   logic [SUM_W-1:0]       sum_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] sum_vld_ff;
   logic [SUM_W-1:0]       sum_rd_ff;
   logic [VAL_W-1:0]       norm_mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] norm_vld_ff;
   logic [VAL_W-1:0]       norm_rd_ff;

   logic [COL_W-1:0]     raddr;
   logic                 sum_we, sum_clr, norm_we;
   logic [SUM_W-1:0]     sum_wdata;
   logic                 slot_free;

   logic [SUM_W:0]       acc_sum;
   logic [SUM_W-1:0]     sq_t;
   logic [VAL_W:0]       div_t;
   logic [RES_W-1:0]     qmag;

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      prod_in     = prod_ff;
      x_in        = x_ff;
      res_in      = res_ff;
      bit_in      = bit_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      q_in        = q_ff;
      dl_in       = dl_ff;
      nv_in       = nv_ff;
      ovf_in      = ovf_ff;
      out_vld_in  = out_vld_ff & ~rsp_pop;
      out_kind_in = out_kind_ff;
      out_col_in  = out_col_ff;
      out_val_in  = out_val_ff;
      out_zero_in = out_zero_ff;
      out_last_in = out_last_ff;
      slot_free   = ~out_vld_ff | rsp_pop;
      fifo_pop    = 1'b0;
      raddr       = col_ff;
      sum_we      = 1'b0;
      sum_clr     = 1'b0;
      norm_we     = 1'b0;
      acc_sum     = {1'b0, sum_rd_ff} + {1'b0, prod_ff};
      sum_wdata   = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
      sq_t        = res_ff + bit_ff;
      div_t       = {rem_ff, dl_ff[VAL_W-1]};
      qmag        = '0;

      case (state_ff)
         ST_IDLE: begin
            raddr = head.col;
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               col_in   = head.col;
               neg_in   = head.neg;
               mag_in   = head.mag;
               prod_in  = SUM_W'(head.mag) * SUM_W'(head.mag);
               case (head.op)
                  OP_ACC:  state_in = ST_A_ADD;
                  OP_FIN: begin
                     col_in   = '0;
                     state_in = ST_F_RD;
                  end
                  OP_NRM:  state_in = ST_N_CHK;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_A_ADD: begin
            sum_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_F_RD: begin
            state_in = ST_F_INIT;
         end
         ST_F_INIT: begin
            x_in     = sum_rd_ff;
            res_in   = '0;
            bit_in   = SUM_W'(1) << (SUM_W - 2);
            cnt_in   = '0;
            state_in = ST_F_SQ;
         end
         ST_F_SQ: begin
            if (x_ff >= sq_t) begin
               x_in   = x_ff - sq_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_F_OUT;
            end
         end
         ST_F_OUT: begin
            if (slot_free) begin
               norm_we     = 1'b1;
               out_vld_in  = 1'b1;
               out_kind_in = KIND_NORM;
               out_col_in  = col_ff;
               out_val_in  = {1'b0, res_ff[VAL_W-1:0]};
               out_zero_in = res_ff[VAL_W-1:0] == '0;
               out_last_in = {1'b0, col_ff} == ncols - 1'b1;
               if ({1'b0, col_ff} == ncols - 1'b1) begin
                  sum_clr  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_F_RD;
               end
            end
         end
         ST_N_CHK: begin
            nv_in  = norm_rd_ff;
            rem_in = {2'b00, mag_ff[VAL_W-1:2]};
            dl_in  = {mag_ff[1:0], {(VAL_W-2){1'b0}}};
            ovf_in = {2'b00, mag_ff[VAL_W-1:2]} >= norm_rd_ff;
            q_in   = '0;
            cnt_in = '0;
            state_in = (norm_rd_ff == '0) ? ST_N_OUT : ST_N_DIV;
         end
         ST_N_DIV: begin
            if (div_t >= {1'b0, nv_ff}) begin
               rem_in = VAL_W'(div_t - {1'b0, nv_ff});
               q_in   = {q_ff[VAL_W-2:0], 1'b1};
            end else begin
               rem_in = div_t[VAL_W-1:0];
               q_in   = {q_ff[VAL_W-2:0], 1'b0};
            end
            dl_in  = dl_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_N_OUT;
            end
         end
         ST_N_OUT: begin
            if (slot_free) begin
               out_vld_in  = 1'b1;
               out_kind_in = KIND_ELEM;
               out_col_in  = col_ff;
               out_last_in = 1'b1;
               out_zero_in = nv_ff == '0;
               if (nv_ff == '0) begin
                  out_val_in = '0;
               end else if (neg_ff) begin
                  // saturate magnitude at 2^31, then negate
                  qmag = (ovf_ff || (q_ff > 32'h8000_0000)) ? 33'h0_8000_0000
                                                             : {1'b0, q_ff};
                  out_val_in = RES_W'(0) - qmag;
               end else begin
                  out_val_in = (ovf_ff || q_ff[VAL_W-1]) ? 33'h0_7FFF_FFFF
                                                         : {1'b0, q_ff};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_vld_ff  <= out_vld_in;
         col_ff      <= col_in;
         neg_ff      <= neg_in;
         mag_ff      <= mag_in;
         prod_ff     <= prod_in;
         x_ff        <= x_in;
         res_ff      <= res_in;
         bit_ff      <= bit_in;
         cnt_ff      <= cnt_in;
         rem_ff      <= rem_in;
         q_ff        <= q_in;
         dl_ff       <= dl_in;
         nv_ff       <= nv_in;
         ovf_ff      <= ovf_in;
         out_kind_ff <= out_kind_in;
         out_col_ff  <= out_col_in;
         out_val_ff  <= out_val_in;
         out_zero_ff <= out_zero_in;
         out_last_ff <= out_last_in;
      end
   end

   // valid bits: an invalid entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff  <= '0;
         norm_vld_ff <= '0;
      end else begin
         if (sum_clr) begin
            sum_vld_ff <= '0;
         end else if (sum_we) begin
            sum_vld_ff[col_ff] <= 1'b1;
         end
         if (norm_we) begin
            norm_vld_ff[col_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[col_ff] <= sum_wdata;
      end
      sum_rd_ff <= sum_vld_ff[raddr] ? sum_mem[raddr] : '0;
   end

   always_ff @(posedge clock) begin
      if (norm_we) begin
         norm_mem[col_ff] <= res_ff[VAL_W-1:0];
      end
      norm_rd_ff <= norm_vld_ff[raddr] ? norm_mem[raddr] : '0;
   end

   assign rsp_empty         = ~out_vld_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_result_column = out_col_ff;
   assign rsp_result_value  = out_val_ff;
   assign rsp_zero_norm     = out_zero_ff;
   assign rsp_last_result   = out_last_ff;

endmodule

### hdl/cln_checker.sv
// Port-level checks of the normalizer, bound to the top level.
module cln_checker
   import cln_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input logic                     rsp_result_kind,
   input logic signed [RES_W-1:0]  rsp_result_value,
   input logic                     rsp_zero_norm,
   input logic                     rsp_last_result
);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> rsp_empty)
      else $error("result shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result_value)))
      else $error("stalled result beat changed");

   a_elem_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == KIND_ELEM) |-> rsp_last_result)
      else $error("element beat without last flag");

   a_norm_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_result_kind == KIND_NORM) |->
         (rsp_zero_norm == (rsp_result_value == '0)))
      else $error("zero flag disagrees with norm");

   a_elem_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_zero_norm) |-> (rsp_result_value == '0))
      else $error("zero-norm beat with nonzero value");

endmodule

bind column_two_norm_normalizer_top cln_checker u_cln_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_result_value (rsp_result_value),
   .rsp_zero_norm    (rsp_zero_norm),
   .rsp_last_result  (rsp_last_result)
);
